>>> design/sccb_pkg.sv
// ----------------------------------------------------------------------------
// SCCB register master package
// Transaction types, operation codes and register map shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package sccb_pkg;

	// Width of the pin hold counter
	localparam int HOLD_W = 16;

	// APB address width: three 32-bit registers at byte offsets 0, 4, 8
	localparam int PADDR_W = 4;

	// Operation codes carried by a request
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_DEV_WR = 2'd0;
	localparam logic [1:0] REG_DEV_RD = 2'd1;
	localparam logic [1:0] REG_HALF   = 2'd2;

	// Byte slots sent on the bus
	localparam logic [1:0] BYTE_DEV_WR = 2'd0;
	localparam logic [1:0] BYTE_REG    = 2'd1;
	localparam logic [1:0] BYTE_DATA   = 2'd2;
	localparam logic [1:0] BYTE_DEV_RD = 2'd3;

	// Reset values of the configuration registers
	localparam logic [7:0]        DEV_WR_RESET = 8'h42;
	localparam logic [7:0]        DEV_RD_RESET = 8'h43;
	localparam logic [HOLD_W-1:0] HALF_RESET   = 16'd5000;

	// Value read back on a nack during a read
	localparam logic [7:0] NACK_READ_BYTE = 8'hFF;

	// One clock tick of request
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] target_reg;
		logic [7:0] write_data;
		logic       sda_in;
	} sccb_req_t;

	// Pin levels and status after one tick
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] read_data;
	} sccb_res_t;

endpackage

`default_nettype wire

>>> design/sccb_register_master.sv
// ----------------------------------------------------------------------------
// SCCB register master
// Camera register write/read sequencer; each request transaction is one tick
// of bus timing and yields one transaction of pin levels and status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  req     | in        | req_valid/req_stall | sccb_req_t (tick inputs)
//  res     | out       | res_valid/res_stall | sccb_res_t (pins, status)
//  apb     | in/out    | psel/penable/pready | 32-bit config registers
//
// One request transaction is taken every cycle while the result channel is not
// stalled; its result is registered in the result register when it leaves the
// input register, and results keep request order.
// The sequencer state advances once per request, in the cycle it leaves the
// input register. Reset puts the bus lines high, the sequencer idle and the
// config registers at their defaults. A stalled result holds both stages;
// the input register takes a new transaction whenever it is empty or its
// content moves on.
`default_nettype none

module sccb_register_master (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire sccb_pkg::sccb_req_t          req,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output sccb_pkg::sccb_res_t               res,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sccb_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	typedef enum logic [4:0] {
		S_IDLE      = 5'd0,
		S_ST_SDA_H  = 5'd1,
		S_ST_SCL_H  = 5'd2,
		S_ST_SDA_L  = 5'd3,
		S_ST_SCL_L  = 5'd4,
		S_TX_SDA    = 5'd5,
		S_TX_SCL_H  = 5'd6,
		S_TX_SCL_L  = 5'd7,
		S_ACK_SCL_H = 5'd8,
		S_ACK_SCL_L = 5'd9,
		S_SP_SDA_L  = 5'd10,
		S_SP_SCL_H  = 5'd11,
		S_SP_SDA_H  = 5'd12,
		S_SP_END    = 5'd13,
		S_RX_SCL_H  = 5'd14,
		S_RX_SCL_L  = 5'd15,
		S_NA_SDA_H  = 5'd16,
		S_NA_SCL_H  = 5'd17,
		S_NA_SCL_L  = 5'd18,
		S_NA_SDA_L  = 5'd19
	} step_t;

	// Configuration registers
	logic [7:0]                  dev_wr_q;
	logic [7:0]                  dev_rd_q;
	logic [sccb_pkg::HOLD_W-1:0] half_q;

	// Sequencer state
	step_t                       step_q,    step_n;
	logic [sccb_pkg::HOLD_W-1:0] hold_q,    hold_n;
	logic [3:0]                  bitcnt_q,  bitcnt_n;
	logic [1:0]                  byteidx_q, byteidx_n;
	logic [7:0]                  shift_q,   shift_n;
	logic                        is_read_q, is_read_n;
	logic [7:0]                  capt_q,    capt_n;
	logic                        nack_q,    nack_n;
	logic                        scl_q,     scl_n;
	logic                        sda_q,     sda_n;
	logic                        drive_q,   drive_n;
	logic [7:0]                  reg_lat_q, reg_lat_n;
	logic [7:0]                  dat_lat_q, dat_lat_n;
	logic                        done_n;

	// Pipeline
	logic                  valid_s1;
	sccb_pkg::sccb_req_t   req_s1;
	logic                  valid_s2;
	sccb_pkg::sccb_res_t   res_s2;
	logic                  advance;
	logic                  cfg_wr;
	logic [sccb_pkg::HOLD_W-1:0] arm_val;

	// Byte to send for a given slot
	function automatic logic [7:0] pick_byte(
		input logic [1:0] idx,
		input logic [7:0] dev_wr,
		input logic [7:0] reg_lat,
		input logic [7:0] dat_lat,
		input logic [7:0] dev_rd
	);
		logic [7:0] b;
		case (idx)
			sccb_pkg::BYTE_DEV_WR: b = dev_wr;
			sccb_pkg::BYTE_REG:    b = reg_lat;
			sccb_pkg::BYTE_DATA:   b = dat_lat;
			default:               b = dev_rd;
		endcase
		return b;
	endfunction

	// Handshake: the result stage moves when empty or taken
	assign advance   = !valid_s2 || !res_stall;
	assign req_stall = valid_s1 && !advance;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			sccb_pkg::REG_DEV_WR: prdata = {24'd0, dev_wr_q};
			sccb_pkg::REG_DEV_RD: prdata = {24'd0, dev_rd_q};
			sccb_pkg::REG_HALF:   prdata = {16'd0, half_q};
			default:              prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_wr_q <= sccb_pkg::DEV_WR_RESET;
			dev_rd_q <= sccb_pkg::DEV_RD_RESET;
			half_q   <= sccb_pkg::HALF_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				sccb_pkg::REG_DEV_WR: dev_wr_q <= pwdata[7:0];
				sccb_pkg::REG_DEV_RD: dev_rd_q <= pwdata[7:0];
				sccb_pkg::REG_HALF:   half_q   <= pwdata[sccb_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold count reloaded on every pin action; zero acts as one
	assign arm_val = (half_q == '0) ? '0 : half_q - 1'b1;

	// Next sequencer state for the tick in stage 1
	always_comb begin
		step_n    = step_q;
		hold_n    = hold_q;
		bitcnt_n  = bitcnt_q;
		byteidx_n = byteidx_q;
		shift_n   = shift_q;
		is_read_n = is_read_q;
		capt_n    = capt_q;
		nack_n    = nack_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		drive_n   = drive_q;
		reg_lat_n = reg_lat_q;
		dat_lat_n = dat_lat_q;
		done_n    = 1'b0;

		if (hold_q != '0) begin
			hold_n = hold_q - 1'b1;
		end else begin
			case (step_q)
				S_IDLE: begin
					if (req_s1.operation == sccb_pkg::OP_WRITE ||
					    req_s1.operation == sccb_pkg::OP_READ) begin
						is_read_n = (req_s1.operation == sccb_pkg::OP_READ);
						reg_lat_n = req_s1.target_reg;
						dat_lat_n = req_s1.write_data;
						nack_n    = 1'b0;
						byteidx_n = sccb_pkg::BYTE_DEV_WR;
						bitcnt_n  = 4'd0;
						sda_n     = 1'b1;
						hold_n    = arm_val;
						step_n    = S_ST_SCL_H;
					end
				end
				// start condition
				S_ST_SDA_H: begin
					sda_n = 1'b1; hold_n = arm_val; step_n = S_ST_SCL_H;
				end
				S_ST_SCL_H: begin
					scl_n = 1'b1; hold_n = arm_val; step_n = S_ST_SDA_L;
				end
				S_ST_SDA_L: begin
					sda_n = 1'b0; hold_n = arm_val; step_n = S_ST_SCL_L;
				end
				S_ST_SCL_L: begin
					scl_n    = 1'b0;
					hold_n   = arm_val;
					shift_n  = pick_byte(byteidx_q, dev_wr_q, reg_lat_q, dat_lat_q,
						dev_rd_q);
					bitcnt_n = 4'd0;
					step_n   = S_TX_SDA;
				end
				// byte out, MSB first
				S_TX_SDA: begin
					sda_n = shift_q[7]; hold_n = arm_val; step_n = S_TX_SCL_H;
				end
				S_TX_SCL_H: begin
					scl_n = 1'b1; hold_n = arm_val; step_n = S_TX_SCL_L;
				end
				S_TX_SCL_L: begin
					scl_n    = 1'b0;
					hold_n   = arm_val;
					shift_n  = {shift_q[6:0], 1'b0};
					bitcnt_n = bitcnt_q + 4'd1;
					step_n   = (bitcnt_n >= 4'd8) ? S_ACK_SCL_H : S_TX_SDA;
				end
				// acknowledge slot
				S_ACK_SCL_H: begin
					drive_n = 1'b0; scl_n = 1'b1; hold_n = arm_val;
					step_n  = S_ACK_SCL_L;
				end
				S_ACK_SCL_L: begin
					scl_n   = 1'b0;
					hold_n  = arm_val;
					drive_n = 1'b1;
					if (req_s1.sda_in) begin
						nack_n = 1'b1;
						if (is_read_q) capt_n = sccb_pkg::NACK_READ_BYTE;
						step_n = S_SP_SDA_L;
					end else if (!is_read_q) begin
						if (byteidx_q < sccb_pkg::BYTE_DATA) begin
							byteidx_n = byteidx_q + 2'd1;
							shift_n   = pick_byte(byteidx_n, dev_wr_q, reg_lat_q,
								dat_lat_q, dev_rd_q);
							bitcnt_n  = 4'd0;
							step_n    = S_TX_SDA;
						end else begin
							step_n = S_SP_SDA_L;
						end
					end else if (byteidx_q == sccb_pkg::BYTE_DEV_WR) begin
						byteidx_n = sccb_pkg::BYTE_REG;
						shift_n   = reg_lat_q;
						bitcnt_n  = 4'd0;
						step_n    = S_TX_SDA;
					end else if (byteidx_q == sccb_pkg::BYTE_REG) begin
						step_n = S_SP_SDA_L;
					end else begin
						bitcnt_n = 4'd0;
						shift_n  = 8'd0;
						step_n   = S_RX_SCL_H;
					end
				end
				// byte in, sampled as SCL falls
				S_RX_SCL_H: begin
					drive_n = 1'b0; scl_n = 1'b1; hold_n = arm_val;
					step_n  = S_RX_SCL_L;
				end
				S_RX_SCL_L: begin
					shift_n  = {shift_q[6:0], req_s1.sda_in};
					scl_n    = 1'b0;
					hold_n   = arm_val;
					bitcnt_n = bitcnt_q + 4'd1;
					if (bitcnt_n >= 4'd8) begin
						drive_n = 1'b1;
						capt_n  = shift_n;
						step_n  = S_NA_SDA_H;
					end else begin
						step_n = S_RX_SCL_H;
					end
				end
				// master no-ack
				S_NA_SDA_H: begin
					sda_n = 1'b1; hold_n = arm_val; step_n = S_NA_SCL_H;
				end
				S_NA_SCL_H: begin
					scl_n = 1'b1; hold_n = arm_val; step_n = S_NA_SCL_L;
				end
				S_NA_SCL_L: begin
					scl_n = 1'b0; hold_n = arm_val; step_n = S_NA_SDA_L;
				end
				S_NA_SDA_L: begin
					sda_n = 1'b0; hold_n = arm_val; step_n = S_SP_SDA_L;
				end
				// stop condition
				S_SP_SDA_L: begin
					sda_n = 1'b0; hold_n = arm_val; step_n = S_SP_SCL_H;
				end
				S_SP_SCL_H: begin
					scl_n = 1'b1; hold_n = arm_val; step_n = S_SP_SDA_H;
				end
				S_SP_SDA_H: begin
					sda_n = 1'b1; hold_n = arm_val; step_n = S_SP_END;
				end
				S_SP_END: begin
					// read: after register select, restart with the read address
					if (is_read_q && !nack_q && byteidx_q == sccb_pkg::BYTE_REG) begin
						byteidx_n = sccb_pkg::BYTE_DEV_RD;
						sda_n     = 1'b1;
						hold_n    = arm_val;
						step_n    = S_ST_SCL_H;
					end else begin
						done_n = 1'b1;
						step_n = S_IDLE;
					end
				end
				default: begin
					step_n = S_IDLE;
				end
			endcase
		end
	end

	// Input register, sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			step_q    <= S_IDLE;
			hold_q    <= '0;
			bitcnt_q  <= 4'd0;
			byteidx_q <= 2'd0;
			shift_q   <= 8'd0;
			is_read_q <= 1'b0;
			capt_q    <= 8'd0;
			nack_q    <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			drive_q   <= 1'b1;
			reg_lat_q <= 8'd0;
			dat_lat_q <= 8'd0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && advance) begin
				step_q    <= step_n;
				hold_q    <= hold_n;
				bitcnt_q  <= bitcnt_n;
				byteidx_q <= byteidx_n;
				shift_q   <= shift_n;
				is_read_q <= is_read_n;
				capt_q    <= capt_n;
				nack_q    <= nack_n;
				scl_q     <= scl_n;
				sda_q     <= sda_n;
				drive_q   <= drive_n;
				reg_lat_q <= reg_lat_n;
				dat_lat_q <= dat_lat_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
		if (valid_s1 && advance) begin
			res_s2.scl_out   <= scl_n;
			res_s2.sda_out   <= sda_n;
			res_s2.sda_drive <= drive_n;
			res_s2.busy_res  <= (step_n != S_IDLE);
			res_s2.done_res  <= done_n;
			res_s2.status    <= nack_n;
			res_s2.read_data <= capt_n;
		end
	end

endmodule

`default_nettype wire
